@@ rtl/core/cmtsa_pkg.sv @@
// shared constants, widths and the arctangent table of the cube texel core
`timescale 1ns / 1ps

package cmtsa_pkg;

	// configuration and field widths
	localparam int FACE_SIZE_W = 9;
	localparam logic [FACE_SIZE_W-1:0] FACE_SIZE_RESET = 9'd64;
	localparam int MAX_FACE_SIZE = 256;
	localparam int FACE_W = 3;
	localparam int COORD_W = 8;
	localparam int DIR_W = 17;
	localparam int SA_W = 22;
	localparam int IDX_W = 16;

	// face codes
	localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
	localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

	// corner numerators and area datapath
	localparam int CORNER_W = 11;
	localparam int X2_W = 41;
	localparam int ISQ_W = 64;
	localparam int XY_W = 40;
	localparam int Z_W = 34;
	localparam int ISQRT_STAGES = 32;
	localparam int CORDIC_STAGES = 20;
	localparam int AREA_PRE = 5;
	localparam int AREA_LAT = AREA_PRE + ISQRT_STAGES + CORDIC_STAGES;

	// direction datapath
	localparam int R2_W = 20;
	localparam int MAG_W = 10;
	localparam int SRCH_BITS = 16;
	localparam int SRCH_W = 58;
	localparam int DIR_STAGE = SRCH_BITS + 4;

	// whole pipe
	localparam int TOTAL_STAGES = AREA_LAT + 3;
	localparam int DIR_DLY = TOTAL_STAGES - 1 - DIR_STAGE;
	localparam int SIDE_DLY = TOTAL_STAGES - 2;
	localparam int SUM_W = 36;
	localparam logic [SA_W-1:0] SA_MAX = {SA_W{1'b1}};

	// atan(2^-i) in Q.30, floor
	function automatic logic [31:0] atan_step(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd843314856;
			1: r = 32'd497837829;
			2: r = 32'd263043836;
			3: r = 32'd133525158;
			4: r = 32'd67021686;
			5: r = 32'd33543515;
			6: r = 32'd16775850;
			7: r = 32'd8388437;
			8: r = 32'd4194282;
			9: r = 32'd2097149;
			default: begin
				if (i <= 30) r = (32'd1 << (30 - i)) - 32'd1;
				else r = 32'd0;
			end
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/cube_map_texel_direction_solid_angle_core.sv @@
// top level of the cube map texel direction and solid angle core
`timescale 1ns / 1ps

// One texel (face, row, col) enters per clock; the pipe depth is set by the four
// corner-angle pipes (a 32-stage square root followed by a 20-stage cordic per
// corner), and the direction search (16 stages, one result bit each) is padded to
// the same length. The pipe runs at one texel per cycle as long as the result side
// does not stall; a stall with a result waiting freezes the whole pipe and holds
// item_stall high. face_size may only be rewritten while the pipe is empty. Texels
// with a bad face, a zero or oversized face_size, or row/col beyond the face
// return texel_ok low with all other fields zero.
module cube_map_texel_direction_solid_angle_core import cmtsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   face_size_we,
	input  logic [FACE_SIZE_W-1:0] face_size_wdata,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [FACE_W-1:0]      face,
	input  logic [COORD_W-1:0]     row,
	input  logic [COORD_W-1:0]     col,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic signed [DIR_W-1:0] dir_x,
	output logic signed [DIR_W-1:0] dir_y,
	output logic signed [DIR_W-1:0] dir_z,
	output logic [SA_W-1:0]        solid_angle,
	output logic [IDX_W-1:0]       texel_index,
	output logic                   texel_ok
);

	logic [FACE_SIZE_W-1:0] face_size_q;
	logic en;
	logic [TOTAL_STAGES:1] vld_s;

	logic [FACE_W-1:0] face_s1;
	logic [COORD_W-1:0] row_s1, col_s1;
	logic [FACE_SIZE_W-1:0] n_s1;
	logic ok_s1;
	logic [IDX_W-1:0] idx_s1;

	logic signed [CORNER_W-1:0] a_c, b_c, nn_c, cx0_c, cx1_c, dy0_c, dy1_c;
	logic signed [CORNER_W-1:0] p_c [3];
	logic signed [2*CORNER_W-1:0] aa_c, bb_c;
	logic [2*FACE_SIZE_W-1:0] nsq_c;

	logic signed [CORNER_W-1:0] p_s2 [3];
	logic [R2_W-1:0] aa_s2, bb_s2, nn_s2;

	logic [R2_W-1:0] r2_s3;
	logic [SRCH_W-1:0] rhs_s3 [3];
	logic neg_s3 [3];
	logic [MAG_W-1:0] mag_c [3];

	logic [SRCH_BITS-1:0] srch_m_s [3][SRCH_BITS+1];
	logic [SRCH_W-1:0] srch_mr_s [3][SRCH_BITS+1];
	logic [SRCH_W-1:0] srch_m2r_s [3][SRCH_BITS+1];
	logic [SRCH_W-1:0] srch_rhs_s [3][SRCH_BITS+1];
	logic srch_neg_s [3][SRCH_BITS+1];
	logic [R2_W-1:0] srch_r2_s [SRCH_BITS+1];

	logic signed [DIR_W-1:0] dir_s20 [3];
	logic signed [DIR_W-1:0] dir_dly_q [DIR_DLY][3];
	logic ok_dly_q [SIDE_DLY];
	logic [IDX_W-1:0] idx_dly_q [SIDE_DLY];

	logic signed [Z_W-1:0] z11, z01, z10, z00;
	logic signed [SUM_W-1:0] sum_s59, rnd_c;

	logic signed [DIR_W-1:0] dirx_s60, diry_s60, dirz_s60;
	logic [SA_W-1:0] sa_s60;
	logic [IDX_W-1:0] idx_s60;
	logic ok_s60;

	// face size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= FACE_SIZE_RESET;
		end else if (face_size_we) begin
			face_size_q <= face_size_wdata;
		end
	end

	// global pipe advance
	assign en = !vld_s[TOTAL_STAGES] || !result_stall;
	assign item_stall = !en;
	assign result_valid = vld_s[TOTAL_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOTAL_STAGES-1:1], item_valid};
		end
	end

	// stage 1: capture beat, range check, linear index
	always_ff @(posedge clk) begin
		if (en) begin
			face_s1 <= face;
			row_s1 <= row;
			col_s1 <= col;
			n_s1 <= face_size_q;
			ok_s1 <= (face <= FACE_NZ) && (face_size_q != '0)
				&& (face_size_q <= FACE_SIZE_W'(MAX_FACE_SIZE))
				&& ({1'b0, row} < face_size_q) && ({1'b0, col} < face_size_q);
			idx_s1 <= IDX_W'(17'(row) * 17'(face_size_q) + 17'(col));
		end
	end

	// texel center and corner numerators
	assign nn_c = $signed({2'b00, n_s1});
	assign a_c = $signed({2'b00, col_s1, 1'b1}) - nn_c;
	assign b_c = $signed({2'b00, row_s1, 1'b1}) - nn_c;
	assign cx0_c = $signed({2'b00, col_s1, 1'b0}) - nn_c;
	assign cx1_c = cx0_c + CORNER_W'(2);
	assign dy0_c = $signed({2'b00, row_s1, 1'b0}) - nn_c;
	assign dy1_c = dy0_c + CORNER_W'(2);

	// face orientation
	always_comb begin
		case (face_s1)
			FACE_PX: begin p_c[0] = nn_c;  p_c[1] = -b_c; p_c[2] = a_c;   end
			FACE_NX: begin p_c[0] = -nn_c; p_c[1] = -b_c; p_c[2] = -a_c;  end
			FACE_PY: begin p_c[0] = a_c;   p_c[1] = nn_c; p_c[2] = -b_c;  end
			FACE_NY: begin p_c[0] = a_c;   p_c[1] = -nn_c; p_c[2] = b_c;  end
			FACE_PZ: begin p_c[0] = -a_c;  p_c[1] = -b_c; p_c[2] = nn_c;  end
			default: begin p_c[0] = a_c;   p_c[1] = -b_c; p_c[2] = -nn_c; end
		endcase
	end

	assign aa_c = a_c * a_c;
	assign bb_c = b_c * b_c;
	assign nsq_c = n_s1 * n_s1;

	// stage 2: point and squares
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= p_c;
			aa_s2 <= aa_c[R2_W-1:0];
			bb_s2 <= bb_c[R2_W-1:0];
			nn_s2 <= R2_W'(nsq_c);
		end
	end

	// stage 3: radius squared and compare targets
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mag_c[j] = p_s2[j][CORNER_W-1] ? MAG_W'(-p_s2[j]) : MAG_W'(p_s2[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s3 <= aa_s2 + bb_s2 + nn_s2;
			for (int j = 0; j < 3; j++) begin
				rhs_s3[j] <= SRCH_W'(mag_c[j] * mag_c[j]) << 32;
				neg_s3[j] <= p_s2[j][CORNER_W-1];
			end
		end
	end

	// search start
	assign srch_r2_s[0] = r2_s3;
	for (genvar gj = 0; gj < 3; gj++) begin : g_init
		assign srch_m_s[gj][0] = '0;
		assign srch_mr_s[gj][0] = '0;
		assign srch_m2r_s[gj][0] = '0;
		assign srch_rhs_s[gj][0] = rhs_s3[gj];
		assign srch_neg_s[gj][0] = neg_s3[gj];
	end

	for (genvar gb = 0; gb < SRCH_BITS; gb++) begin : g_r2
		always_ff @(posedge clk) begin
			if (en) srch_r2_s[gb+1] <= srch_r2_s[gb];
		end
	end

	// magnitude search, one bit per stage, products kept by shifts and adds
	for (genvar gj = 0; gj < 3; gj++) begin : g_comp
		for (genvar gb = 0; gb < SRCH_BITS; gb++) begin : g_bit
			localparam int BIT = SRCH_BITS - 1 - gb;
			logic [SRCH_W-1:0] r2w_c, tr_c, t2r_c, o2r_c;
			assign r2w_c = SRCH_W'(srch_r2_s[gb]);
			assign tr_c = srch_mr_s[gj][gb] + (r2w_c << BIT);
			assign t2r_c = srch_m2r_s[gj][gb] + (srch_mr_s[gj][gb] << (BIT + 1))
				+ (r2w_c << (2 * BIT));
			assign o2r_c = (t2r_c << 2) - (tr_c << 2) + r2w_c;
			always_ff @(posedge clk) begin
				if (en) begin
					if (o2r_c <= srch_rhs_s[gj][gb]) begin
						srch_m_s[gj][gb+1] <= srch_m_s[gj][gb] | (SRCH_BITS'(1) << BIT);
						srch_mr_s[gj][gb+1] <= tr_c;
						srch_m2r_s[gj][gb+1] <= t2r_c;
					end else begin
						srch_m_s[gj][gb+1] <= srch_m_s[gj][gb];
						srch_mr_s[gj][gb+1] <= srch_mr_s[gj][gb];
						srch_m2r_s[gj][gb+1] <= srch_m2r_s[gj][gb];
					end
					srch_rhs_s[gj][gb+1] <= srch_rhs_s[gj][gb];
					srch_neg_s[gj][gb+1] <= srch_neg_s[gj][gb];
				end
			end
		end
	end

	// apply sign
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				dir_s20[j] <= srch_neg_s[j][SRCH_BITS]
					? -$signed({1'b0, srch_m_s[j][SRCH_BITS]})
					: $signed({1'b0, srch_m_s[j][SRCH_BITS]});
			end
		end
	end

	// align direction, flag and index with the area path
	always_ff @(posedge clk) begin
		if (en) begin
			dir_dly_q[0] <= dir_s20;
			for (int i = 1; i < DIR_DLY; i++) dir_dly_q[i] <= dir_dly_q[i-1];
			ok_dly_q[0] <= ok_s1;
			idx_dly_q[0] <= idx_s1;
			for (int i = 1; i < SIDE_DLY; i++) begin
				ok_dly_q[i] <= ok_dly_q[i-1];
				idx_dly_q[i] <= idx_dly_q[i-1];
			end
		end
	end

	// four corner terms
	cmtsa_area u_area11 (.clk(clk), .en(en), .c(cx1_c), .d(dy1_c), .n(n_s1), .z(z11));
	cmtsa_area u_area01 (.clk(clk), .en(en), .c(cx0_c), .d(dy1_c), .n(n_s1), .z(z01));
	cmtsa_area u_area10 (.clk(clk), .en(en), .c(cx1_c), .d(dy0_c), .n(n_s1), .z(z10));
	cmtsa_area u_area00 (.clk(clk), .en(en), .c(cx0_c), .d(dy0_c), .n(n_s1), .z(z00));

	// combine corners
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s59 <= SUM_W'(z11) - SUM_W'(z01) - SUM_W'(z10) + SUM_W'(z00);
		end
	end

	assign rnd_c = (sum_s59 + SUM_W'(512)) >>> 10;

	// output register: round, saturate, zero bad texels
	always_ff @(posedge clk) begin
		if (en) begin
			ok_s60 <= ok_dly_q[SIDE_DLY-1];
			idx_s60 <= ok_dly_q[SIDE_DLY-1] ? idx_dly_q[SIDE_DLY-1] : '0;
			dirx_s60 <= ok_dly_q[SIDE_DLY-1] ? dir_dly_q[DIR_DLY-1][0] : '0;
			diry_s60 <= ok_dly_q[SIDE_DLY-1] ? dir_dly_q[DIR_DLY-1][1] : '0;
			dirz_s60 <= ok_dly_q[SIDE_DLY-1] ? dir_dly_q[DIR_DLY-1][2] : '0;
			if (!ok_dly_q[SIDE_DLY-1] || sum_s59[SUM_W-1]) begin
				sa_s60 <= '0;
			end else if (rnd_c > $signed(SUM_W'(SA_MAX))) begin
				sa_s60 <= SA_MAX;
			end else begin
				sa_s60 <= rnd_c[SA_W-1:0];
			end
		end
	end

	assign dir_x = dirx_s60;
	assign dir_y = diry_s60;
	assign dir_z = dirz_s60;
	assign solid_angle = sa_s60;
	assign texel_index = idx_s60;
	assign texel_ok = ok_s60;

endmodule

@@ rtl/core/cmtsa_area.sv @@
// one corner term atan2(c*d, n*sqrt(c*c+d*d+n*n)) through square root and cordic pipes
`timescale 1ns / 1ps

module cmtsa_area import cmtsa_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [CORNER_W-1:0] c,
	input  logic signed [CORNER_W-1:0] d,
	input  logic [FACE_SIZE_W-1:0]     n,
	output logic signed [Z_W-1:0]      z
);

	logic signed [2*CORNER_W-1:0] cc_c, dd_c, cd_c;
	logic [2*FACE_SIZE_W-1:0] nsq_c;
	logic [2*CORNER_W-2:0] cc_s1, dd_s1;
	logic signed [2*CORNER_W-1:0] cd_s1, cd_s2, cd_s3, cd_s4;
	logic [2*FACE_SIZE_W-1:0] nn_s1, nn_s2;
	logic [22:0] sum_s2;
	logic [X2_W-1:0] x2_s3, x2_s4;
	logic [5:0] msb_c;
	logic [4:0] k_s4;

	logic [ISQ_W-1:0] iv_s [ISQRT_STAGES+1];
	logic [ISQ_W-1:0] ir_s [ISQRT_STAGES+1];
	logic signed [XY_W-1:0] iy_s [ISQRT_STAGES+1];

	logic signed [XY_W-1:0] cx_s [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] cy_s [CORDIC_STAGES+1];
	logic signed [Z_W-1:0] cz_s [CORDIC_STAGES+1];

	logic signed [ISQ_W-1:0] ysh_c;

	// squares and cross product
	assign cc_c = c * c;
	assign dd_c = d * d;
	assign cd_c = c * d;
	assign nsq_c = n * n;

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1 <= cc_c[2*CORNER_W-2:0];
			dd_s1 <= dd_c[2*CORNER_W-2:0];
			cd_s1 <= cd_c;
			nn_s1 <= nsq_c;
		end
	end

	// radius squared sum
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= 23'(cc_s1) + 23'(dd_s1) + 23'(nn_s1);
			nn_s2 <= nn_s1;
			cd_s2 <= cd_s1;
		end
	end

	// scale by n squared
	always_ff @(posedge clk) begin
		if (en) begin
			x2_s3 <= X2_W'(nn_s2) * X2_W'(sum_s2);
			cd_s3 <= cd_s2;
		end
	end

	// leading one and normalizing shift
	always_comb begin
		msb_c = 6'd0;
		for (int i = 0; i < X2_W; i++) begin
			if (x2_s3[i]) msb_c = 6'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s4 <= x2_s3;
			k_s4 <= 5'((6'd61 - msb_c) >> 1);
			cd_s4 <= cd_s3;
		end
	end

	// apply the shift
	assign ysh_c = ISQ_W'(cd_s4) <<< k_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			iv_s[0] <= ISQ_W'(x2_s4) << {k_s4, 1'b0};
			ir_s[0] <= '0;
			iy_s[0] <= ysh_c[XY_W-1:0];
		end
	end

	// square root, one result bit per stage
	for (genvar g = 0; g < ISQRT_STAGES; g++) begin : g_isqrt
		localparam logic [ISQ_W-1:0] BITV = ISQ_W'(1) << (62 - 2 * g);
		logic [ISQ_W-1:0] trial_c;
		assign trial_c = ir_s[g] + BITV;
		always_ff @(posedge clk) begin
			if (en) begin
				if (iv_s[g] >= trial_c) begin
					iv_s[g+1] <= iv_s[g] - trial_c;
					ir_s[g+1] <= (ir_s[g] >> 1) + BITV;
				end else begin
					iv_s[g+1] <= iv_s[g];
					ir_s[g+1] <= ir_s[g] >> 1;
				end
				iy_s[g+1] <= iy_s[g];
			end
		end
	end

	// cordic vectoring start
	assign cx_s[0] = XY_W'(ir_s[ISQRT_STAGES]);
	assign cy_s[0] = iy_s[ISQRT_STAGES];
	assign cz_s[0] = '0;

	// cordic vectoring, one rotation per stage
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_step(g));
		logic signed [XY_W-1:0] dx_c, dy_c;
		assign dx_c = cy_s[g] >>> g;
		assign dy_c = cx_s[g] >>> g;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[g][XY_W-1]) begin
					cx_s[g+1] <= cx_s[g] + dx_c;
					cy_s[g+1] <= cy_s[g] - dy_c;
					cz_s[g+1] <= cz_s[g] + ANG;
				end else begin
					cx_s[g+1] <= cx_s[g] - dx_c;
					cy_s[g+1] <= cy_s[g] + dy_c;
					cz_s[g+1] <= cz_s[g] - ANG;
				end
			end
		end
	end

	assign z = cz_s[CORDIC_STAGES];

endmodule
